### rtl/assert_macros.svh
// assertion macros used by the nec ir pulse decoder back part
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/nirpd_pkg.sv
// types and constants of the nec ir pulse decoder
// no dependencies
`default_nettype none

package nirpd_pkg;

    localparam int TIME_W       = 16;
    localparam int CODE_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int ACC_IDX_W    = $clog2(CODE_W);
    localparam int NUM_CFG_REGS = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int QUEUE_DEPTH  = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEADER_MIN = 3'd0,
        REG_LEADER_MAX = 3'd1,
        REG_ZERO_MIN   = 3'd2,
        REG_ZERO_MAX   = 3'd3,
        REG_ONE_MIN    = 3'd4,
        REG_ONE_MAX    = 3'd5
    } cfg_idx_t;

    localparam logic [CFG_DATA_W-1:0] CFG_RESET [NUM_CFG_REGS] =
        '{16'd1300, 16'd1400, 16'd100, 16'd120, 16'd210, 16'd235};

    // bit value carried by one interval
    typedef enum logic [1:0] {
        BIT_NONE = 2'd0,
        BIT_ZERO = 2'd1,
        BIT_ONE  = 2'd2
    } bit_kind_t;

    // classification of one interval, front to back
    typedef struct packed {
        logic      leader_hit;
        bit_kind_t bit_kind;
    } interval_class_t;

endpackage

`default_nettype wire

### rtl/nirpd_if.sv
// valid/ready channel interfaces of the nec ir pulse decoder
// uses nirpd_pkg for field widths
`default_nettype none

// capture timestamp channel
interface nirpd_capture_if;
    logic                          valid;
    logic                          ready;
    logic [nirpd_pkg::TIME_W-1:0]  capture_time;

    modport source (output valid, output capture_time, input ready);
    modport sink   (input valid, input capture_time, output ready);
endinterface

// decoded frame channel
interface nirpd_frame_if;
    logic                          valid;
    logic                          ready;
    logic [nirpd_pkg::CODE_W-1:0]  frame_code;
    logic [nirpd_pkg::BYTE_W-1:0]  address_byte;
    logic [nirpd_pkg::BYTE_W-1:0]  command_byte;

    modport source (output valid, output frame_code, output address_byte,
                    output command_byte, input ready);
    modport sink   (input valid, input frame_code, input address_byte,
                    input command_byte, output ready);
endinterface

`default_nettype wire

### rtl/nirpd_front.sv
// front part: config registers, interval from previous capture, window classification
// uses nirpd_pkg and nirpd_capture_if
`default_nettype none

module nirpd_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    nirpd_capture_if.sink                           capture,
    input  wire logic                               cfg_we,
    input  wire logic [nirpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nirpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                    push_valid,
    input  wire logic                               push_ready,
    output nirpd_pkg::interval_class_t              push_data
);

    logic [nirpd_pkg::CFG_DATA_W-1:0] cfg_reg [nirpd_pkg::NUM_CFG_REGS];
    logic [nirpd_pkg::TIME_W-1:0]     prev_time_reg;
    logic [nirpd_pkg::TIME_W-1:0]     interval;
    logic                             leader_win;
    logic                             zero_win;
    logic                             one_win;

    // transaction passes straight into the queue
    assign capture.ready = push_ready;
    assign push_valid    = capture.valid;

    // wrapped interval, modulo the timer width
    assign interval = capture.capture_time - prev_time_reg;

    // inclusive windows
    assign leader_win = (interval >= cfg_reg[nirpd_pkg::REG_LEADER_MIN]) &&
                        (interval <= cfg_reg[nirpd_pkg::REG_LEADER_MAX]);
    assign zero_win   = (interval >= cfg_reg[nirpd_pkg::REG_ZERO_MIN]) &&
                        (interval <= cfg_reg[nirpd_pkg::REG_ZERO_MAX]);
    assign one_win    = (interval >= cfg_reg[nirpd_pkg::REG_ONE_MIN]) &&
                        (interval <= cfg_reg[nirpd_pkg::REG_ONE_MAX]);

    // zero window wins where windows overlap
    always_comb
    begin
        push_data.leader_hit = leader_win;
        if (zero_win)
        begin
            push_data.bit_kind = nirpd_pkg::BIT_ZERO;
        end
        else if (one_win)
        begin
            push_data.bit_kind = nirpd_pkg::BIT_ONE;
        end
        else
        begin
            push_data.bit_kind = nirpd_pkg::BIT_NONE;
        end
    end

    // previous capture time and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            for (int i = 0; i < nirpd_pkg::NUM_CFG_REGS; i++)
            begin
                cfg_reg[i] <= nirpd_pkg::CFG_RESET[i];
            end
        end
        else
        begin
            if (capture.valid && capture.ready)
            begin
                prev_time_reg <= capture.capture_time;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    nirpd_pkg::REG_LEADER_MIN: cfg_reg[nirpd_pkg::REG_LEADER_MIN] <= cfg_data;
                    nirpd_pkg::REG_LEADER_MAX: cfg_reg[nirpd_pkg::REG_LEADER_MAX] <= cfg_data;
                    nirpd_pkg::REG_ZERO_MIN:   cfg_reg[nirpd_pkg::REG_ZERO_MIN]   <= cfg_data;
                    nirpd_pkg::REG_ZERO_MAX:   cfg_reg[nirpd_pkg::REG_ZERO_MAX]   <= cfg_data;
                    nirpd_pkg::REG_ONE_MIN:    cfg_reg[nirpd_pkg::REG_ONE_MIN]    <= cfg_data;
                    nirpd_pkg::REG_ONE_MAX:    cfg_reg[nirpd_pkg::REG_ONE_MAX]    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### rtl/nirpd_queue.sv
// short queue of classified intervals between front and back
// uses nirpd_pkg
`default_nettype none

module nirpd_queue (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push_valid,
    output logic                              push_ready,
    input  wire nirpd_pkg::interval_class_t   push_data,
    output logic                              pop_valid,
    input  wire logic                         pop_ready,
    output nirpd_pkg::interval_class_t        pop_data
);

    localparam int PTR_W = (nirpd_pkg::QUEUE_DEPTH > 1) ? $clog2(nirpd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(nirpd_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(nirpd_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(nirpd_pkg::QUEUE_DEPTH);

    nirpd_pkg::interval_class_t slot_reg [nirpd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/nirpd_back.sv
// back part: frame tracking, bit placement by index, checksum and output register
// uses nirpd_pkg, nirpd_frame_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module nirpd_back #(
    parameter int FRAME_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pop_valid,
    output logic                              pop_ready,
    input  wire nirpd_pkg::interval_class_t   pop_data,
    nirpd_frame_if.source                     frame
);

    localparam int CNT_W = $clog2(FRAME_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BITS);

    logic                          in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]              bits_reg, bits_next;
    logic [nirpd_pkg::CODE_W-1:0]  acc_reg, acc_next;
    logic                          out_valid_reg, out_valid_next;
    logic [nirpd_pkg::CODE_W-1:0]  code_reg;
    logic [CNT_W-1:0]              bits_dec;
    logic [nirpd_pkg::ACC_IDX_W-1:0] bit_idx;
    logic [nirpd_pkg::CODE_W-1:0]  acc_set;
    logic                          take;
    logic                          emit;

    // address and data bytes each sum with their complements to all ones
    function automatic logic checksum_ok(input logic [nirpd_pkg::CODE_W-1:0] code);
        logic [nirpd_pkg::BYTE_W:0] addr_sum;
        logic [nirpd_pkg::BYTE_W:0] data_sum;
        addr_sum = {1'b0, code[31:24]} + {1'b0, code[23:16]};
        data_sum = {1'b0, code[15:8]} + {1'b0, code[7:0]};
        return (addr_sum == 9'h0FF) && (data_sum == 9'h0FF);
    endfunction

    // take an interval when the output slot is free or draining
    assign pop_ready = !out_valid_reg || frame.ready;
    assign take      = pop_valid && pop_ready;

    // next bit lands at position bits_remaining - 1
    assign bits_dec = bits_reg - 1'b1;
    assign bit_idx  = nirpd_pkg::ACC_IDX_W'(bits_dec);

    always_comb
    begin
        acc_set          = acc_reg;
        acc_set[bit_idx] = (pop_data.bit_kind == nirpd_pkg::BIT_ONE);
    end

    // frame state update
    always_comb
    begin
        in_frame_next = in_frame_reg;
        bits_next     = bits_reg;
        acc_next      = acc_reg;
        emit          = 1'b0;
        if (take)
        begin
            if (!in_frame_reg)
            begin
                if (pop_data.leader_hit)
                begin
                    in_frame_next = 1'b1;
                    bits_next     = CNT_FULL;
                    acc_next      = '0;
                end
            end
            else if (pop_data.bit_kind == nirpd_pkg::BIT_NONE)
            begin
                in_frame_next = 1'b0;
                bits_next     = CNT_FULL;
                acc_next      = '0;
            end
            else if (bits_dec == '0)
            begin
                in_frame_next = 1'b0;
                bits_next     = CNT_FULL;
                acc_next      = '0;
                emit          = checksum_ok(acc_set);
            end
            else
            begin
                bits_next = bits_dec;
                acc_next  = acc_set;
            end
        end
    end

    // output register valid
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            bits_reg      <= CNT_FULL;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            bits_reg      <= bits_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            code_reg <= acc_set;
        end
    end

    assign frame.valid        = out_valid_reg;
    assign frame.frame_code   = code_reg;
    assign frame.address_byte = code_reg[31:24];
    assign frame.command_byte = code_reg[15:8];

    // checks
    `ASSERT_IMPLY(a_frame_count_range, in_frame_reg, (bits_reg != '0) && (bits_reg <= CNT_FULL))
    `ASSERT_IMPLY(a_hunt_clean, !in_frame_reg, (bits_reg == CNT_FULL) && (acc_reg == '0))
    `ASSERT_NEXT(a_emit_shows, emit, out_valid_reg && checksum_ok(code_reg))
    `ASSERT_IMPLY(a_emit_needs_space, emit, !out_valid_reg || frame.ready)

endmodule

`default_nettype wire

### rtl/nec_ir_pulse_decoder_top.sv
// top level of the nec ir pulse decoder: front, queue and back
// uses nirpd_pkg, nirpd_if, nirpd_front, nirpd_queue, nirpd_back
//
// channel    direction  handshake      payload
// capture    in         valid/ready    capture_time[15:0]
// frame      out        valid/ready    frame_code[31:0], address_byte[7:0], command_byte[7:0]
// cfg        in         cfg_we         cfg_index[2:0], cfg_data[15:0]
//
// one capture per cycle sustained; after its last capture a frame passes the queue slot, then the output register
// the two-entry queue parts classification from frame tracking, so input stalls only
// once a waiting frame blocks the back part and the queue has filled
// reset restores the config defaults and hunts for a leader; no clearing pass
`default_nettype none

module nec_ir_pulse_decoder_top #(
    parameter int FRAME_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    nirpd_capture_if.sink                           capture,
    nirpd_frame_if.source                           frame,
    input  wire logic                               cfg_we,
    input  wire logic [nirpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nirpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                       push_valid;
    logic                       push_ready;
    nirpd_pkg::interval_class_t push_data;
    logic                       pop_valid;
    logic                       pop_ready;
    nirpd_pkg::interval_class_t pop_data;

    // interval and window classification
    nirpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .capture    (capture),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    nirpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // frame assembly and output
    nirpd_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .frame     (frame)
    );

endmodule

`default_nettype wire

### verif/nec_ir_pulse_decoder_top_tb.sv
// testbench of the nec ir pulse decoder top level: directed and random capture timestamps
// under several timing windows, each decoded frame checked against an in-bench decoder
// depends on nirpd_pkg, nirpd_if and nec_ir_pulse_decoder_top
module nec_ir_pulse_decoder_top_tb;

    localparam int FRAME_BITS    = 32;
    localparam int IDLE_PCT      = 23;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TIME_W        = nirpd_pkg::TIME_W;
    localparam int CODE_W        = nirpd_pkg::CODE_W;
    localparam int BYTE_W        = nirpd_pkg::BYTE_W;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] command;
    } frame_t;

    typedef logic [TIME_W-1:0] stamp_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [nirpd_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [nirpd_pkg::CFG_DATA_W-1:0]  cfg_data;

    nirpd_capture_if capture_ch ();
    nirpd_frame_if   frame_ch ();

    // decoder state mirrored in the bench
    stamp_t                tick_window [nirpd_pkg::NUM_CFG_REGS];
    stamp_t                last_edge_time = '0;
    logic                  frame_open     = 1'b0;
    logic [5:0]            bits_left      = 6'(FRAME_BITS);
    logic [CODE_W-1:0]     code_shift     = '0;

    // stimulus and bookkeeping
    stamp_t                edges_to_send [$];
    frame_t                frames_due [$];
    stamp_t                gen_time       = '0;
    int                    edges_queued   = 0;
    int                    edges_taken    = 0;
    int                    frames_checked = 0;
    int                    fail_count     = 0;
    int                    settings_run   = 1;
    int                    cycle_count    = 0;
    bit                    steady         = 1'b0;
    int                    hold_asked     = 0;
    int                    holds_done     = 0;
    int                    hold_left      = 0;

    always #5 clk = ~clk;

    nec_ir_pulse_decoder_top #(
        .FRAME_BITS (FRAME_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .capture   (capture_ch),
        .frame     (frame_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // interval check against one inclusive window; min above max never matches
    function automatic logic in_window(input stamp_t gap, input nirpd_pkg::cfg_idx_t lo_reg,
                                       input nirpd_pkg::cfg_idx_t hi_reg);
        return gap >= tick_window[lo_reg] && gap <= tick_window[hi_reg];
    endfunction

    function automatic void drop_frame();
        frame_open = 1'b0;
        bits_left  = 6'(FRAME_BITS);
        code_shift = '0;
    endfunction

    // one accepted edge: interval, leader hunt, bit sort, checksum
    function automatic void decode_edge(input stamp_t now);
        stamp_t            gap;
        logic              bit_val;
        frame_t            done;
        gap = now - last_edge_time;
        last_edge_time = now;
        if (!frame_open)
        begin
            if (in_window(gap, nirpd_pkg::REG_LEADER_MIN, nirpd_pkg::REG_LEADER_MAX))
            begin
                frame_open = 1'b1;
                bits_left  = 6'(FRAME_BITS);
                code_shift = '0;
            end
            return;
        end
        // zero window has priority where the windows overlap
        if (in_window(gap, nirpd_pkg::REG_ZERO_MIN, nirpd_pkg::REG_ZERO_MAX))
            bit_val = 1'b0;
        else if (in_window(gap, nirpd_pkg::REG_ONE_MIN, nirpd_pkg::REG_ONE_MAX))
            bit_val = 1'b1;
        else
        begin
            drop_frame();
            return;
        end
        code_shift[bits_left - 6'd1] = bit_val;
        bits_left = bits_left - 6'd1;
        if (bits_left != 0)
            return;
        done.code    = code_shift;
        done.address = code_shift[31:24];
        done.command = code_shift[15:8];
        drop_frame();
        if ({1'b0, done.code[31:24]} + {1'b0, done.code[23:16]} == 9'h0ff &&
            {1'b0, done.code[15:8]} + {1'b0, done.code[7:0]} == 9'h0ff)
            frames_due.push_back(done);
    endfunction

    // random value inside a window, or its low bound when the window is empty
    function automatic stamp_t pick(input nirpd_pkg::cfg_idx_t lo_reg,
                                    input nirpd_pkg::cfg_idx_t hi_reg);
        if (tick_window[lo_reg] <= tick_window[hi_reg])
            return TIME_W'($urandom_range(tick_window[hi_reg], tick_window[lo_reg]));
        return tick_window[lo_reg];
    endfunction

    function automatic stamp_t bit_gap(input logic bit_val);
        return bit_val ? pick(nirpd_pkg::REG_ONE_MIN, nirpd_pkg::REG_ONE_MAX)
                       : pick(nirpd_pkg::REG_ZERO_MIN, nirpd_pkg::REG_ZERO_MAX);
    endfunction

    function automatic void send_gap(input stamp_t gap);
        gen_time = gen_time + gap;
        edges_to_send.push_back(gen_time);
        edges_queued++;
    endfunction

    // leader then the code msb first; bad_slot names a bit replaced by a random gap
    function automatic void send_frame(input logic [CODE_W-1:0] code, input int bad_slot);
        send_gap(pick(nirpd_pkg::REG_LEADER_MIN, nirpd_pkg::REG_LEADER_MAX));
        for (int i = FRAME_BITS - 1; i >= 0; i--)
        begin
            if (i == bad_slot)
                send_gap(TIME_W'($urandom));
            else
                send_gap(bit_gap(code[i]));
        end
    endfunction

    // mostly well-formed frames, the rest broken frames and noise
    function automatic void add_random_traffic(input int budget);
        int                stop_at;
        int                kind;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] cmd;
        logic [CODE_W-1:0] code;
        stop_at = edges_queued + budget;
        while (edges_queued < stop_at)
        begin
            kind = $urandom_range(99);
            addr = BYTE_W'($urandom);
            cmd  = BYTE_W'($urandom);
            code = {addr, ~addr, cmd, ~cmd};
            if (kind < 80)
                send_frame(code, -1);
            else if (kind < 85)
                send_frame(CODE_W'($urandom), -1);
            else if (kind < 90)
                send_frame(code ^ (32'h1 << $urandom_range(31)), -1);
            else if (kind < 94)
                send_frame(code, $urandom_range(FRAME_BITS - 1));
            else if (kind < 97)
            begin
                // truncated frame left open
                send_gap(pick(nirpd_pkg::REG_LEADER_MIN, nirpd_pkg::REG_LEADER_MAX));
                repeat ($urandom_range(FRAME_BITS - 1, 1))
                    send_gap(bit_gap(1'($urandom_range(1))));
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    send_gap(TIME_W'($urandom));
            end
        end
    endfunction

    task automatic program_window(input nirpd_pkg::cfg_idx_t lo_reg,
                                  input nirpd_pkg::cfg_idx_t hi_reg,
                                  input stamp_t lo, input stamp_t hi);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= lo_reg;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= hi_reg;
        cfg_data  <= hi;
        tick_window[lo_reg] = lo;
        tick_window[hi_reg] = hi;
    endtask

    task automatic set_windows(input stamp_t lead_lo, input stamp_t lead_hi,
                               input stamp_t zero_lo, input stamp_t zero_hi,
                               input stamp_t one_lo, input stamp_t one_hi);
        program_window(nirpd_pkg::REG_LEADER_MIN, nirpd_pkg::REG_LEADER_MAX, lead_lo, lead_hi);
        program_window(nirpd_pkg::REG_ZERO_MIN, nirpd_pkg::REG_ZERO_MAX, zero_lo, zero_hi);
        program_window(nirpd_pkg::REG_ONE_MIN, nirpd_pkg::REG_ONE_MAX, one_lo, one_hi);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // all edges sent, all frames back, and the pipeline given time to empty
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (edges_to_send.size() != 0 || capture_ch.valid || frames_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // capture driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_ch.valid        <= 1'b0;
            capture_ch.capture_time <= '0;
        end
        else if (!capture_ch.valid || capture_ch.ready)
        begin
            if (edges_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                capture_ch.valid        <= 1'b1;
                capture_ch.capture_time <= edges_to_send.pop_front();
            end
            else
            begin
                capture_ch.valid <= 1'b0;
            end
        end
    end

    // frame receiver with random stalls and long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ch.ready <= 1'b0;
        end
        else if (holds_done != hold_asked)
        begin
            holds_done     = hold_asked;
            hold_left      = HOLD_CYCLES;
            frame_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left      = hold_left - 1;
            frame_ch.ready <= 1'b0;
        end
        else
        begin
            frame_ch.ready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // monitor: predict on each capture transaction, check each frame transaction
    always @(posedge clk)
    begin : monitor
        frame_t want;
        if (rst_n)
        begin
            if (capture_ch.valid && capture_ch.ready)
            begin
                decode_edge(capture_ch.capture_time);
                edges_taken++;
            end
            if (frame_ch.valid && frame_ch.ready)
            begin
                frames_checked++;
                if (frames_due.size() == 0)
                begin
                    $display("%0t: unexpected frame, expected none, actual code %h",
                             $time, frame_ch.frame_code);
                    fail_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (frame_ch.frame_code !== want.code)
                    begin
                        $display("%0t: frame_code expected %h actual %h",
                                 $time, want.code, frame_ch.frame_code);
                        fail_count++;
                    end
                    if (frame_ch.address_byte !== want.address)
                    begin
                        $display("%0t: address_byte expected %h actual %h",
                                 $time, want.address, frame_ch.address_byte);
                        fail_count++;
                    end
                    if (frame_ch.command_byte !== want.command)
                    begin
                        $display("%0t: command_byte expected %h actual %h",
                                 $time, want.command, frame_ch.command_byte);
                        fail_count++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d frames still expected",
                     cycle_count, frames_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        stamp_t lead_lo;
        stamp_t zero_lo;
        stamp_t zero_hi;
        stamp_t one_lo;

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = nirpd_pkg::REG_LEADER_MIN;
        cfg_data                = '0;
        capture_ch.valid        = 1'b0;
        capture_ch.capture_time = '0;
        frame_ch.ready          = 1'b0;
        foreach (tick_window[i])
            tick_window[i] = nirpd_pkg::CFG_RESET[i];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset windows: boundaries, wrap, equal stamps, drops
        @(negedge clk);
        send_gap(16'd0);        // first edge, interval from zero
        send_gap(16'd0);        // equal timestamps
        send_gap(16'hffff);     // wraps the timer
        send_gap(16'd1299);     // just short of a leader
        send_gap(16'd1401);     // just past a leader
        send_gap(16'd1300);     // leader at its low bound
        send_gap(16'd99);       // bad bit drops the frame
        send_gap(16'd1400);     // leader at its high bound
        send_gap(16'd100);
        send_gap(16'd120);
        send_gap(16'd210);
        send_gap(16'd235);
        send_gap(16'd121);      // between windows, drop
        send_gap(16'd1350);
        send_gap(16'd1350);     // leader inside a frame drops, not a restart
        send_gap(16'd236);
        send_gap(16'd209);
        wait_quiet();

        // long receiver hold-off while frames keep coming
        hold_asked = hold_asked + 1;
        add_random_traffic(450);
        wait_quiet();

        // random windows, no idling on either side
        lead_lo = TIME_W'($urandom_range(60000, 2000));
        zero_lo = TIME_W'($urandom_range(500));
        zero_hi = zero_lo + TIME_W'($urandom_range(300));
        one_lo  = zero_hi + TIME_W'($urandom_range(500, 1));
        set_windows(lead_lo, lead_lo + TIME_W'($urandom_range(3000)), zero_lo, zero_hi,
                    one_lo, one_lo + TIME_W'($urandom_range(500)));
        steady = 1'b1;
        @(negedge clk);
        add_random_traffic(200);
        wait_quiet();
        steady = 1'b0;

        // extreme bounds: zero window from 0, one and leader up to the top
        set_windows(16'd60000, 16'hffff, 16'd0, 16'd40, 16'd41, 16'hffff);
        @(negedge clk);
        send_gap(16'hffff);     // leader at the top bound
        send_gap(16'd0);        // equal stamps as a zero bit
        send_gap(16'd40);
        send_gap(16'd41);
        send_gap(16'hffff);
        add_random_traffic(150);
        wait_quiet();

        // overlapping bit windows
        set_windows(16'd1300, 16'd1400, 16'd100, 16'd240, 16'd230, 16'd300);
        @(negedge clk);
        send_gap(16'd1300);
        send_gap(16'd230);      // in both windows, sorted as zero
        send_gap(16'd241);
        send_gap(16'd99);
        add_random_traffic(150);
        wait_quiet();

        // every gap a leader, zero window empty
        set_windows(16'd0, 16'hffff, 16'd120, 16'd100, 16'd210, 16'd235);
        @(negedge clk);
        add_random_traffic(80);
        wait_quiet();

        // back to the reset values
        set_windows(16'd1300, 16'd1400, 16'd100, 16'd120, 16'd210, 16'd235);
        @(negedge clk);
        add_random_traffic(250);
        wait_quiet();

        $display("summary: %0d capture transactions over %0d window settings",
                 edges_taken, settings_run);
        $display("summary: %0d frame transactions checked, %0d mismatches",
                 frames_checked, fail_count);
        if (fail_count == 0 && frames_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
